### rtl/pwlcr_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width LED chain receiver package
// Timing windows and the result word type shared by the receiver.
// ----------------------------------------------------------------------------
package pwlcr_pkg;

  // Width of the edge interval and of the count register.
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned CountWidth    = 11;

  // Timing thresholds in nanoseconds (all comparisons are strict).
  localparam logic [IntervalWidth-1:0] FrameGapMin  = 16'd50000;
  localparam logic [IntervalWidth-1:0] LowValidMin  = 16'd400;
  localparam logic [IntervalWidth-1:0] LowValidMax  = 16'd951;
  localparam logic [IntervalWidth-1:0] LowOneMax    = 16'd751;
  localparam logic [IntervalWidth-1:0] LowZeroMin   = 16'd649;
  localparam logic [IntervalWidth-1:0] HighValidMin = 16'd199;
  localparam logic [IntervalWidth-1:0] HighValidMax = 16'd851;
  localparam logic [IntervalWidth-1:0] HighLongMin  = 16'd500;

  // Bit and byte positions within one 24-bit colour word.
  localparam logic [2:0] BitFirst  = 3'd7;
  localparam logic [2:0] BitLast   = 3'd0;
  localparam logic [1:0] ByteFirst = 2'd0;
  localparam logic [1:0] ByteLast  = 2'd2;

  // One result word.
  typedef struct packed {
    logic       pass_update;
    logic       pass_level;
    logic       led_write;
    logic [9:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

endpackage

### rtl/pulse_width_led_chain_receiver.sv
// ----------------------------------------------------------------------------
// Pulse-width LED chain receiver
// Decodes a single-wire pulse-width LED data stream, one line edge per word.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (sample_valid, sample_stall, rising, interval) carries
//   one edge of the data line per word: its direction and the time in ns
//   since the previous edge. Every accepted edge produces exactly one result
//   word on the result channel (result_valid, result_stall): either a
//   pass-through level update, a finished LED colour write, or an empty word.
//   Each result is registered. Throughput is one edge per clock while
//   sample_stall is low; the edge decode is a single pass of compare and
//   shift logic between the sample port and the result register.
//   When the receiver stalls, a result is parked in a one-word skid register
//   so the next edge is still taken; sample_stall rises only once both the
//   result register and the skid register are occupied.
//   The user writes led_count via cfg_wen/cfg_wdata only while the block is
//   idle; the block does not enforce this. Synchronous reset clears the frame
//   state, sets led_count to 1 and empties the result and skid registers.
// ----------------------------------------------------------------------------
module pulse_width_led_chain_receiver #(
  parameter int unsigned MAX_LEDS = 1024
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Configuration
  input  logic                                    cfg_wen,
  input  logic [pwlcr_pkg::CountWidth-1:0]        cfg_wdata,
  // Edge samples
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  logic                                    rising,
  input  logic [pwlcr_pkg::IntervalWidth-1:0]     interval,
  // Results
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic                                    pass_update,
  output logic                                    pass_level,
  output logic                                    led_write,
  output logic [9:0]                              led_index,
  output logic [7:0]                              red,
  output logic [7:0]                              green,
  output logic [7:0]                              blue
);

  import pwlcr_pkg::*;

  // Word position must reach MAX_LEDS itself; compares run at a common width.
  localparam int unsigned WordWidth = $clog2(MAX_LEDS + 1);
  localparam int unsigned CmpWidth  = (WordWidth > CountWidth) ? WordWidth : CountWidth;

  // Registers.
  logic [CountWidth-1:0] led_count;
  logic [7:0]            shift_byte;
  logic [2:0]            bit_position;
  logic [1:0]            byte_position;
  logic [WordWidth-1:0]  word_position;
  logic                  long_high_seen;
  logic                  fresh_word;
  logic [7:0]            held_bytes [2];
  result_t               out_word;
  result_t               skid_word;
  logic                  skid_valid;

  // Next values.
  logic [7:0]            shift_byte_next;
  logic [2:0]            bit_position_next;
  logic [1:0]            byte_position_next;
  logic [WordWidth-1:0]  word_position_next;
  logic                  long_high_seen_next;
  logic                  fresh_word_next;
  logic                  held_write;
  result_t               result_next;

  // Decode helpers.
  logic                  accept;
  logic                  out_free;
  logic [CmpWidth-1:0]   count_ext;
  logic [CmpWidth-1:0]   count_eff;
  logic [CmpWidth-1:0]   word_ext;
  logic                  full;
  logic                  take;
  logic                  take_one;
  logic [7:0]            merged_byte;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = skid_valid;
  assign out_free     = !result_valid || !result_stall;

  // Effective LED count, limited to MAX_LEDS, and the pass-through test.
  assign count_ext = CmpWidth'(led_count);
  assign count_eff = (count_ext > CmpWidth'(MAX_LEDS)) ? CmpWidth'(MAX_LEDS) : count_ext;
  assign word_ext  = CmpWidth'(word_position);
  assign full      = word_ext >= count_eff;

  // Edge decode: timing windows, bit shifting and word completion.
  always_comb begin
    shift_byte_next     = shift_byte;
    bit_position_next   = bit_position;
    byte_position_next  = byte_position;
    word_position_next  = word_position;
    long_high_seen_next = long_high_seen;
    fresh_word_next     = fresh_word;
    held_write          = 1'b0;
    take                = 1'b0;
    take_one            = 1'b0;
    result_next         = '0;

    if (rising) begin
      fresh_word_next = 1'b1;
      if (interval > FrameGapMin) begin
        shift_byte_next    = '0;
        bit_position_next  = BitFirst;
        byte_position_next = ByteFirst;
        word_position_next = '0;
      end else if (interval > LowValidMin && interval < LowValidMax) begin
        if (full) begin
          result_next.pass_update = 1'b1;
          result_next.pass_level  = 1'b1;
        end else if (fresh_word) begin
          if (long_high_seen) begin
            take     = interval < LowOneMax;
            take_one = 1'b1;
          end else begin
            take     = interval > LowZeroMin;
            take_one = 1'b0;
          end
        end
      end
    end else begin
      if (full) begin
        result_next.pass_update = 1'b1;
        result_next.pass_level  = 1'b0;
      end else if (interval > HighValidMin && interval < HighValidMax) begin
        long_high_seen_next = interval > HighLongMin;
        // The last bit of a word is taken on its falling edge.
        if (byte_position == ByteLast && bit_position == BitLast) begin
          take            = 1'b1;
          take_one        = long_high_seen_next;
          fresh_word_next = 1'b0;
        end
      end
    end

    // Shift the bit into place, MSB first.
    merged_byte               = shift_byte;
    merged_byte[bit_position] = take_one;

    if (take) begin
      if (bit_position != BitLast) begin
        shift_byte_next   = merged_byte;
        bit_position_next = bit_position - 3'd1;
      end else begin
        bit_position_next = BitFirst;
        shift_byte_next   = '0;
        if (byte_position != ByteLast) begin
          held_write         = 1'b1;
          byte_position_next = byte_position + 2'd1;
        end else begin
          result_next.led_write = 1'b1;
          result_next.led_index = word_ext[9:0];
          result_next.green     = held_bytes[0];
          result_next.red       = held_bytes[1];
          result_next.blue      = merged_byte;
          byte_position_next    = ByteFirst;
          word_position_next    = word_position + WordWidth'(1);
        end
      end
    end
  end

  // Frame state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count      <= CountWidth'(1);
      shift_byte     <= '0;
      bit_position   <= BitFirst;
      byte_position  <= ByteFirst;
      word_position  <= '0;
      long_high_seen <= 1'b0;
      fresh_word     <= 1'b1;
    end else begin
      if (cfg_wen) begin
        led_count <= cfg_wdata;
      end
      if (accept) begin
        shift_byte     <= shift_byte_next;
        bit_position   <= bit_position_next;
        byte_position  <= byte_position_next;
        word_position  <= word_position_next;
        long_high_seen <= long_high_seen_next;
        fresh_word     <= fresh_word_next;
      end
    end
  end

  // The first two bytes of a word are held until the third completes.
  always_ff @(posedge clk) begin
    if (accept && held_write) begin
      held_bytes[byte_position[0]] <= merged_byte;
    end
  end

  // Result register with a one-word skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= result_next;
      end
    end else if (accept) begin
      skid_word <= result_next;
    end
  end

  assign pass_update = out_word.pass_update;
  assign pass_level  = out_word.pass_level;
  assign led_write   = out_word.led_write;
  assign led_index   = out_word.led_index;
  assign red         = out_word.red;
  assign green       = out_word.green;
  assign blue        = out_word.blue;

  // A parked result always sits behind a valid result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid register holds a word while the result register is empty");

  // A result word is never both a pass-through update and an LED write.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(pass_update && led_write))
    else $error("result word carries both a pass-through update and an LED write");

  // The word counter never runs past MAX_LEDS.
  assert property (@(posedge clk) disable iff (rst)
    accept && result_next.led_write |=> word_ext <= CmpWidth'(MAX_LEDS))
    else $error("word position ran past MAX_LEDS");

  // An LED write always closes a word: the next bit goes to the first byte.
  assert property (@(posedge clk) disable iff (rst)
    accept && result_next.led_write |=>
      byte_position == ByteFirst && bit_position == BitFirst)
    else $error("bit and byte positions not rewound after an LED write");

endmodule
